@@ rtl/itp_pkg.sv @@
// Shared types, codes and character tables of the infix to postfix converter.
`timescale 1ns / 1ps

package itp_pkg;

    // Stack entry codes
    typedef enum logic [2:0] {
        CODE_OPEN = 3'd0,
        CODE_ADD  = 3'd1,
        CODE_SUB  = 3'd2,
        CODE_MUL  = 3'd3,
        CODE_DIV  = 3'd4,
        CODE_POW  = 3'd5
    } op_code_t;

    // Error codes carried on a result beat
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNMATCHED = 2'd1,
        ERR_INVALID   = 2'd2,
        ERR_OVERFLOW  = 2'd3
    } err_t;

    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;

    // Result beat held between the sequencer and the output register
    typedef struct packed {
        logic [7:0] ch;
        logic       ch_valid;
        err_t       err;
    } result_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // Map an operator character to its code; CODE_OPEN means not an operator
    function automatic op_code_t char_code(input logic [7:0] c);
        op_code_t code;
        case (c)
            CH_ADD:  code = CODE_ADD;
            CH_SUB:  code = CODE_SUB;
            CH_MUL:  code = CODE_MUL;
            CH_DIV:  code = CODE_DIV;
            CH_POW:  code = CODE_POW;
            default: code = CODE_OPEN;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] code_char(input logic [2:0] code);
        logic [7:0] c;
        case (code)
            CODE_OPEN: c = CH_OPEN;
            CODE_ADD:  c = CH_ADD;
            CODE_SUB:  c = CH_SUB;
            CODE_MUL:  c = CH_MUL;
            CODE_DIV:  c = CH_DIV;
            CODE_POW:  c = CH_POW;
            default:   c = 8'h00;
        endcase
        return c;
    endfunction

    // Precedence; an open paren ranks 0 so that it acts as a barrier
    function automatic logic [1:0] code_prec(input logic [2:0] code);
        logic [1:0] p;
        case (code)
            CODE_ADD, CODE_SUB: p = 2'd1;
            CODE_MUL, CODE_DIV: p = 2'd2;
            CODE_POW:           p = 2'd3;
            default:            p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

@@ rtl/itp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/infix_to_postfix_converter_core.sv @@
// Infix to postfix converter: shunting-yard sequencer around an operator stack RAM.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   src      | src_valid / src_stall  | cmd, char_in
//   dst      | dst_valid / dst_stall  | char_out, out_valid, last, error
//
// An open paren is pushed directly; a letter, a bad character or an open paren on a full
// stack gives a held result. An operator, close paren or end runs the pop loop, in which
// each pop but the one that empties the stack waits on the RAM read of the new top, as does
// a matched close that leaves entries below its paren. One item at a time; src_stall is high
// until it is done, and its last result is held back so that last can be set on it.
// Reset empties the stack (count only) and the output register; the RAM is not cleared.
// dst_stall holds the sequencer only when a result has to move and the output is full.
`timescale 1ns / 1ps

module infix_to_postfix_converter_core #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       src_valid,
    output logic       src_stall,
    input  logic       cmd,
    input  logic [7:0] char_in,
    output logic       dst_valid,
    input  logic       dst_stall,
    output logic [7:0] char_out,
    output logic       out_valid,
    output logic       last,
    output logic [1:0] error
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOP,
        S_WAIT,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        K_END,
        K_CLOSE,
        K_OP,
        K_DONE
    } kind_t;

    state_t              state_reg, state_next;
    kind_t               kind_reg, kind_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [2:0]          top_reg, top_next;
    logic [2:0]          code_reg, code_next;
    logic                pend_vld_reg, pend_vld_next;
    itp_pkg::result_t    pend_reg, pend_next;
    logic                dst_valid_reg, dst_valid_next;
    itp_pkg::result_t    out_reg, out_next;
    logic                last_reg, last_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [2:0]          ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [2:0]          ram_rdata;

    logic                out_free;
    logic                can_emit;
    logic                accept;
    logic                do_pop;
    logic                full;
    logic [CW-1:0]       count_dec2;
    itp_pkg::op_code_t   in_code;
    itp_pkg::result_t    res_new;

    itp_ram #(
        .WIDTH(3),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign src_stall  = (state_reg != S_IDLE);
    assign accept     = src_valid && !src_stall;
    assign out_free   = !dst_valid_reg || !dst_stall;
    assign can_emit   = !pend_vld_reg || out_free;
    assign full       = (count_reg == CW'(STACK_DEPTH));
    assign count_dec2 = count_reg - CW'(2);
    assign in_code    = itp_pkg::char_code(char_in);
    assign ram_waddr  = count_reg[AW-1:0];
    assign ram_raddr  = count_dec2[AW-1:0];

    // Pop on end; on close, to its paren; on operator, while the top outranks or matches
    always_comb
    begin
        do_pop = 1'b0;
        if (count_reg != '0)
        begin
            case (kind_reg)
                K_END:   do_pop = 1'b1;
                K_CLOSE: do_pop = (top_reg != itp_pkg::CODE_OPEN);
                K_OP:    do_pop = (itp_pkg::code_prec(code_reg)
                                   <= itp_pkg::code_prec(top_reg))
                                  && (top_reg != itp_pkg::CODE_OPEN);
                default: do_pop = 1'b0;
            endcase
        end
    end

    // Sequencer: decode, pop loop, push, then release the held result with last
    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        code_next      = code_reg;
        pend_vld_next  = pend_vld_reg;
        pend_next      = pend_reg;
        dst_valid_next = dst_valid_reg;
        out_next       = out_reg;
        last_next      = last_reg;
        ram_we         = 1'b0;
        ram_wdata      = itp_pkg::CODE_OPEN;
        res_new        = '{ch: 8'h00, ch_valid: 1'b0, err: itp_pkg::ERR_NONE};

        // Drop a beat the sink has taken
        if (dst_valid_reg && !dst_stall)
        begin
            dst_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    code_next = in_code;
                    if (cmd)
                    begin
                        kind_next  = K_END;
                        state_next = S_LOOP;
                    end
                    else if (itp_pkg::is_letter(char_in))
                    begin
                        pend_next     = '{ch: char_in, ch_valid: 1'b1,
                                          err: itp_pkg::ERR_NONE};
                        pend_vld_next = 1'b1;
                        state_next    = S_FIN;
                    end
                    else if (char_in == itp_pkg::CH_OPEN)
                    begin
                        if (full)
                        begin
                            pend_next     = '{ch: 8'h00, ch_valid: 1'b0,
                                              err: itp_pkg::ERR_OVERFLOW};
                            pend_vld_next = 1'b1;
                            state_next    = S_FIN;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = itp_pkg::CODE_OPEN;
                            top_next   = itp_pkg::CODE_OPEN;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (char_in == itp_pkg::CH_CLOSE)
                    begin
                        kind_next  = K_CLOSE;
                        state_next = S_LOOP;
                    end
                    else if (in_code != itp_pkg::CODE_OPEN)
                    begin
                        kind_next  = K_OP;
                        state_next = S_LOOP;
                    end
                    else
                    begin
                        pend_next     = '{ch: 8'h00, ch_valid: 1'b0,
                                          err: itp_pkg::ERR_INVALID};
                        pend_vld_next = 1'b1;
                        state_next    = S_FIN;
                    end
                end
            end

            S_LOOP:
            begin
                if (do_pop)
                begin
                    res_new = '{ch: itp_pkg::code_char(top_reg), ch_valid: 1'b1,
                                err: itp_pkg::ERR_NONE};
                end
                else if (kind_reg == K_END)
                begin
                    res_new = '{ch: 8'h00, ch_valid: 1'b0, err: itp_pkg::ERR_NONE};
                end
                else if (kind_reg == K_CLOSE)
                begin
                    res_new = '{ch: 8'h00, ch_valid: 1'b0, err: itp_pkg::ERR_UNMATCHED};
                end
                else
                begin
                    res_new = '{ch: 8'h00, ch_valid: 1'b0, err: itp_pkg::ERR_OVERFLOW};
                end

                if (do_pop)
                begin
                    // Emit the top, drop it and fetch the entry below
                    if (can_emit)
                    begin
                        if (pend_vld_reg)
                        begin
                            dst_valid_next = 1'b1;
                            out_next       = pend_reg;
                            last_next      = 1'b0;
                        end
                        pend_next     = res_new;
                        pend_vld_next = 1'b1;
                        count_next    = count_reg - CW'(1);
                        state_next    = (count_reg >= CW'(2)) ? S_WAIT : S_LOOP;
                    end
                end
                else if (kind_reg == K_DONE)
                begin
                    state_next = S_FIN;
                end
                else if (kind_reg == K_CLOSE && count_reg != '0)
                begin
                    // Discard the matching open paren
                    count_next = count_reg - CW'(1);
                    kind_next  = K_DONE;
                    state_next = (count_reg >= CW'(2)) ? S_WAIT : S_FIN;
                end
                else if (kind_reg == K_OP && !full)
                begin
                    // Push the operator
                    ram_we     = 1'b1;
                    ram_wdata  = code_reg;
                    top_next   = code_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_FIN;
                end
                else if (kind_reg == K_END && pend_vld_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    // Empty end marker, unmatched close or overflow result
                    if (can_emit)
                    begin
                        if (pend_vld_reg)
                        begin
                            dst_valid_next = 1'b1;
                            out_next       = pend_reg;
                            last_next      = 1'b0;
                        end
                        pend_next     = res_new;
                        pend_vld_next = 1'b1;
                        state_next    = S_FIN;
                    end
                end
            end

            S_WAIT:
            begin
                // Take the new top from the RAM
                top_next   = ram_rdata;
                state_next = S_LOOP;
            end

            S_FIN:
            begin
                // Release the held result marked last
                if (!pend_vld_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    dst_valid_next = 1'b1;
                    out_next       = pend_reg;
                    last_next      = 1'b1;
                    pend_vld_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state, stack count, payload and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= K_END;
            count_reg     <= '0;
            top_reg       <= itp_pkg::CODE_OPEN;
            code_reg      <= itp_pkg::CODE_OPEN;
            pend_vld_reg  <= 1'b0;
            pend_reg      <= '0;
            dst_valid_reg <= 1'b0;
            out_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            count_reg     <= count_next;
            top_reg       <= top_next;
            code_reg      <= code_next;
            pend_vld_reg  <= pend_vld_next;
            pend_reg      <= pend_next;
            dst_valid_reg <= dst_valid_next;
            out_reg       <= out_next;
            last_reg      <= last_next;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign char_out  = out_reg.ch;
    assign out_valid = out_reg.ch_valid;
    assign last      = last_reg;
    assign error     = out_reg.err;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !pend_vld_reg)
        else $error("held result left over between items");

    a_error_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && error != itp_pkg::ERR_NONE |-> !out_valid && last)
        else $error("error beat carries a character or is not last");

    a_wait_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WAIT |-> $past(state_reg) == S_LOOP)
        else $error("RAM wait entered outside the pop loop");
`endif

endmodule
